@@ rtl/core/assert_macros.svh @@
// assertion helpers included by the cascade rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/core/lsbc_pkg.sv @@
`default_nettype none

package lsbc_pkg;

    // fixed widths
    localparam int CHANNELS    = 8;
    localparam int CH_BITS     = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int COEF_FRAC   = 24;
    localparam int HIST_BITS   = 32;
    localparam int ACC_BITS    = 64;
    localparam int NUM_COEFS   = 12;
    localparam int COEF_IDX_BITS = 4;
    localparam int HIST_DEPTH  = CHANNELS * 8;
    localparam int HIST_ADDR_BITS = $clog2(HIST_DEPTH);
    localparam int STEP_BITS   = 4;

    // coefficient slots
    localparam logic [COEF_IDX_BITS-1:0] HIGH_BASE    = 4'd5;
    localparam logic [COEF_IDX_BITS-1:0] COEF_GAIN    = 4'd10;
    localparam logic [COEF_IDX_BITS-1:0] COEF_NEUTRAL = 4'd11;
    localparam logic [COEF_BITS-1:0]     COEF_ONE     = 32'h0100_0000;

    // bank after reset: identity shelves, unity gain, neutral set
    localparam logic [NUM_COEFS-1:0][COEF_BITS-1:0] COEF_RESET = {
        COEF_BITS'(1), COEF_ONE, {4{COEF_BITS'(0)}}, COEF_ONE, {4{COEF_BITS'(0)}}, COEF_ONE
    };

    // action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;

    // program labels
    localparam logic [STEP_BITS-1:0] STEP_START = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_DONE  = 4'd10;

    typedef struct packed {
        logic [1:0]                   action;
        logic [CH_BITS-1:0]           channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [COEF_IDX_BITS-1:0]     coef_index;
        logic signed [COEF_BITS-1:0]  coef_value;
    } in_item_t;

    typedef struct packed {
        logic [CH_BITS-1:0]            out_channel;
        logic signed [SAMPLE_BITS-1:0] out_sample;
    } out_item_t;

    typedef enum logic [1:0] {
        SRC_X  = 2'd0,
        SRC_RD = 2'd1,
        SRC_Y  = 2'd2
    } operand_t;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NONE    = 2'd0,
        JMP_ALWAYS  = 2'd1,
        JMP_IF_HIGH = 2'd2
    } jmp_t;

    // one control word of the biquad program
    typedef struct packed {
        logic                     rd_en;
        logic [1:0]               rd_slot;
        logic                     mul_en;
        operand_t                 mul_src;
        logic                     coef_rel;
        logic [COEF_IDX_BITS-1:0] coef_idx;
        acc_op_t                  acc_op;
        logic                     rnd;
        logic                     ld_x;
        logic                     wr_en;
        logic [1:0]               wr_slot;
        operand_t                 wr_src;
        jmp_t                     jmp;
        logic [STEP_BITS-1:0]     target;
        logic                     set_high;
        logic                     emit;
    } ucode_t;

    // history slots: x1 x2 y1 y2
    localparam logic [1:0] SLOT_X1 = 2'd0;
    localparam logic [1:0] SLOT_X2 = 2'd1;
    localparam logic [1:0] SLOT_Y1 = 2'd2;
    localparam logic [1:0] SLOT_Y2 = 2'd3;

    // program rom: biquad body shared by both shelves, gain scaling between them
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            4'd0:
            begin
                w.rd_en = 1'b1;  w.rd_slot = SLOT_X1;
                w.mul_en = 1'b1; w.mul_src = SRC_X;  w.coef_rel = 1'b1; w.coef_idx = 4'd0;
            end
            4'd1:
            begin
                w.rd_en = 1'b1;  w.rd_slot = SLOT_X2;
                w.mul_en = 1'b1; w.mul_src = SRC_RD; w.coef_rel = 1'b1; w.coef_idx = 4'd1;
                w.acc_op = ACC_LOAD;
                w.wr_en = 1'b1;  w.wr_slot = SLOT_X2; w.wr_src = SRC_RD;
            end
            4'd2:
            begin
                w.rd_en = 1'b1;  w.rd_slot = SLOT_Y1;
                w.mul_en = 1'b1; w.mul_src = SRC_RD; w.coef_rel = 1'b1; w.coef_idx = 4'd2;
                w.acc_op = ACC_ADD;
                w.wr_en = 1'b1;  w.wr_slot = SLOT_X1; w.wr_src = SRC_X;
            end
            4'd3:
            begin
                w.rd_en = 1'b1;  w.rd_slot = SLOT_Y2;
                w.mul_en = 1'b1; w.mul_src = SRC_RD; w.coef_rel = 1'b1; w.coef_idx = 4'd3;
                w.acc_op = ACC_ADD;
                w.wr_en = 1'b1;  w.wr_slot = SLOT_Y2; w.wr_src = SRC_RD;
            end
            4'd4:
            begin
                w.mul_en = 1'b1; w.mul_src = SRC_RD; w.coef_rel = 1'b1; w.coef_idx = 4'd4;
                w.acc_op = ACC_SUB;
            end
            4'd5:
            begin
                w.acc_op = ACC_SUB;
            end
            4'd6:
            begin
                w.rnd = 1'b1;
            end
            4'd7:
            begin
                w.wr_en = 1'b1;  w.wr_slot = SLOT_Y1; w.wr_src = SRC_Y;
                w.mul_en = 1'b1; w.mul_src = SRC_Y;  w.coef_idx = COEF_GAIN;
                w.jmp = JMP_IF_HIGH; w.target = STEP_DONE;
            end
            4'd8:
            begin
                w.acc_op = ACC_LOAD;
            end
            4'd9:
            begin
                w.rnd = 1'b1; w.ld_x = 1'b1; w.set_high = 1'b1;
                w.jmp = JMP_ALWAYS; w.target = STEP_START;
            end
            4'd10:
            begin
                w.emit = 1'b1;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // 64-bit add that clamps on overflow
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS-1:0] s;
        s = a + b;
        if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (s[ACC_BITS-1] != a[ACC_BITS-1]))
        begin
            s = a[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return s;
    endfunction

    // round half up to Q.24 integer and clamp to 32 bits
    function automatic logic signed [HIST_BITS-1:0] round_q(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] s;
        logic signed [ACC_BITS-1:0] sh;
        logic signed [HIST_BITS-1:0] r;
        s  = sat_add(acc, ACC_BITS'(64'sd1 <<< (COEF_FRAC - 1)));
        sh = s >>> COEF_FRAC;
        if ((&sh[ACC_BITS-1:HIST_BITS-1]) || !(|sh[ACC_BITS-1:HIST_BITS-1]))
        begin
            r = sh[HIST_BITS-1:0];
        end
        else
        begin
            r = sh[ACC_BITS-1] ? {1'b1, {(HIST_BITS-1){1'b0}}}
                               : {1'b0, {(HIST_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // clamp a 32-bit stage value to the sample width
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [HIST_BITS-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if ((&v[HIST_BITS-1:SAMPLE_BITS-1]) || !(|v[HIST_BITS-1:SAMPLE_BITS-1]))
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        else
        begin
            r = v[HIST_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/loudness_shelf_biquad_cascade.sv @@
// loudness correction: low-shelf biquad, gain, high-shelf biquad on a shared multiply-accumulate
// filtered sample: runs the eleven-word program, low shelf and gain, then the shared biquad
// body again for the high shelf, then emit; no new item is taken until the result is emitted
// bypassed samples, coefficient writes and commits complete in the cycle after they are accepted
// reset clears enable, both coefficient banks to identity with neutral set,
// and all filter history through per-entry valid bits, so no clearing pass is needed
`default_nettype none
`include "assert_macros.svh"

module loudness_shelf_biquad_cascade
    import lsbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_item_t      result,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 shelf_reg, shelf_next;
    logic                 result_valid_reg, result_valid_next;
    out_item_t            result_reg, result_next;
    logic                 enable_reg;

    logic [NUM_COEFS-1:0][COEF_BITS-1:0] active_reg;
    logic [NUM_COEFS-1:0][COEF_BITS-1:0] shadow_reg;

    logic signed [HIST_BITS-1:0]   x_reg;
    logic signed [HIST_BITS-1:0]   y_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic [CH_BITS-1:0]            ch_reg;
    logic signed [ACC_BITS-1:0]    prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic [HIST_BITS-1:0]          rd_data_reg;
    logic                          rd_valid_reg;

    logic [HIST_BITS-1:0]      hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]     hist_valid_reg;

    ucode_t                      cw;
    logic                        running;
    logic                        accept;
    logic                        sample_acc;
    logic                        commit_acc;
    logic                        out_free;
    logic                        ch_ok;
    logic                        emit_now;
    logic [COEF_IDX_BITS-1:0]    coef_sel;
    logic signed [HIST_BITS-1:0] rd_eff;
    logic signed [HIST_BITS-1:0] mul_op;
    logic [HIST_BITS-1:0]        wr_data;
    logic [HIST_ADDR_BITS-1:0]   rd_addr;
    logic [HIST_ADDR_BITS-1:0]   wr_addr;
    logic                        cfg_wr;

    // handshake
    assign running      = (state_reg == ST_RUN);
    assign out_free     = !result_valid_reg || result_ready;
    assign item_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept       = item_valid && item_ready;
    assign sample_acc   = accept && (item.action == ACT_SAMPLE);
    assign commit_acc   = accept && (item.action == ACT_COMMIT);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign ch_ok        = ({1'b0, item.channel} < (CH_BITS + 1)'(CHANNELS));

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            enable_reg <= pwdata[0];
        end
    end

    // control word of the current step
    assign cw       = running ? ucode_rom(step_reg) : '0;
    assign emit_now = cw.emit && out_free;

    // coefficient select, high shelf offsets the biquad slots
    assign coef_sel = (cw.coef_rel && shelf_reg) ? (cw.coef_idx + HIGH_BASE) : cw.coef_idx;

    // operand muxes
    assign rd_eff = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        unique case (cw.mul_src)
            SRC_X:   mul_op = x_reg;
            SRC_RD:  mul_op = rd_eff;
            SRC_Y:   mul_op = y_reg;
            default: mul_op = '0;
        endcase
    end

    always_comb
    begin
        unique case (cw.wr_src)
            SRC_X:   wr_data = x_reg;
            SRC_RD:  wr_data = rd_eff;
            SRC_Y:   wr_data = y_reg;
            default: wr_data = '0;
        endcase
    end

    assign rd_addr = {ch_reg, shelf_reg, cw.rd_slot};
    assign wr_addr = {ch_reg, shelf_reg, cw.wr_slot};

    // filter history memory
    always_ff @(posedge clk)
    begin
        if (cw.wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cw.rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // history valid bits, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cw.wr_en)
            begin
                hist_valid_reg[wr_addr] <= 1'b1;
            end
            if (cw.rd_en)
            begin
                rd_valid_reg <= hist_valid_reg[rd_addr];
            end
        end
    end

    // multiply, accumulate, round
    always_ff @(posedge clk)
    begin
        if (cw.mul_en)
        begin
            prod_reg <= $signed(active_reg[coef_sel]) * mul_op;
        end
        unique case (cw.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= sat_add(acc_reg, prod_reg);
            ACC_SUB:  acc_reg <= sat_add(acc_reg, -prod_reg);
            ACC_NONE: acc_reg <= acc_reg;
            default:  acc_reg <= acc_reg;
        endcase
        if (cw.rnd)
        begin
            y_reg <= round_q(acc_reg);
        end
        if (accept)
        begin
            x_reg   <= HIST_BITS'(item.sample);
            smp_reg <= item.sample;
            ch_reg  <= item.channel;
        end
        else if (cw.ld_x)
        begin
            x_reg <= round_q(acc_reg);
        end
    end

    // coefficient banks: shadow writes, atomic commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= COEF_RESET;
            shadow_reg <= COEF_RESET;
        end
        else if (accept)
        begin
            if ((item.action == ACT_WRITE) && (item.coef_index < COEF_IDX_BITS'(NUM_COEFS)))
            begin
                shadow_reg[item.coef_index] <= item.coef_value;
            end
            if (commit_acc)
            begin
                active_reg <= shadow_reg;
            end
        end
    end

    // sequencer and result register
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        shelf_next        = shelf_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        if (sample_acc)
        begin
            if (!enable_reg || !ch_ok)
            begin
                result_valid_next       = 1'b1;
                result_next.out_channel = item.channel;
                result_next.out_sample  = item.sample;
            end
            else
            begin
                state_next = ST_RUN;
                step_next  = STEP_START;
                shelf_next = 1'b0;
            end
        end
        else if (running)
        begin
            if (cw.emit)
            begin
                if (emit_now)
                begin
                    result_valid_next       = 1'b1;
                    result_next.out_channel = ch_reg;
                    result_next.out_sample  = (active_reg[COEF_NEUTRAL] != '0)
                                              ? smp_reg : sat_sample(y_reg);
                    state_next = ST_IDLE;
                    step_next  = STEP_START;
                    shelf_next = 1'b0;
                end
            end
            else
            begin
                if (cw.set_high)
                begin
                    shelf_next = 1'b1;
                end
                priority if (cw.jmp == JMP_ALWAYS)
                begin
                    step_next = cw.target;
                end
                else if ((cw.jmp == JMP_IF_HIGH) && shelf_reg)
                begin
                    step_next = cw.target;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_START;
            shelf_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            shelf_reg        <= shelf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // checks
    `ASSERT_NEVER(a_step_range, clk, rst_n, step_reg > STEP_DONE)
    `ASSERT_NEVER(a_shelf_idle, clk, rst_n, shelf_reg && (state_reg == ST_IDLE))
    `ASSERT_AT(a_commit_only, clk, rst_n, !$stable(active_reg) |-> $past(commit_acc))
    `ASSERT_AT(a_result_src, clk, rst_n, $rose(result_valid_reg) |-> $past(emit_now || sample_acc))

endmodule

`default_nettype wire
